### rtl/core/jcsr_pkg.sv
// jcsr_pkg: shared constants, codes and types of the jitter checked sample ring
// used by jitter_checked_sample_ring and its port checker; no dependencies
package jcsr_pkg;

   // parameter defaults
   localparam int RING_DEPTH_DEF   = 1024;
   localparam int FRAME_LENGTH_DEF = 1024;

   // field widths
   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 12;
   localparam int OP_W     = 2;
   localparam int MODE_W   = 2;
   localparam int PERIOD_W = 16;
   localparam int TOL_W    = 16;
   localparam int FILL_W   = 3;

   // stream packing
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [1:0] REG_PERIOD    = 2'd0;
   localparam logic [1:0] REG_TOLERANCE = 2'd1;
   localparam logic [1:0] REG_FILL      = 2'd2;

   // register reset values
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd250;
   localparam logic [TOL_W-1:0]    TOL_RST    = 16'd20;
   localparam logic [FILL_W-1:0]   FILL_RST   = 3'd3;

   // operation codes
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // sync machine codes, reported as sync_state
   localparam logic [MODE_W-1:0] MODE_IN_SYNC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CALC   = 7'b0000010,
      ST_DECIDE = 7'b0000100,
      ST_FILL   = 7'b0001000,
      ST_SNAP   = 7'b0010000,
      ST_RDATA  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_value;
      logic                sample_valid;
      logic                last_of_frame;
      logic                snapshot_taken;
      logic [MODE_W-1:0]   sync_state;
      logic [TIME_W-1:0]   gap_us;
      logic                gap_valid;
   } rsp_type;

endpackage

### rtl/core/jitter_checked_sample_ring.sv
// sample event: accepted, then through CALC, DECIDE, SNAP and DONE to the output register, with FILL on a resync fill
// read: ring read, then capture in RDATA; arm and unused codes go straight to DONE; next request taken after that
// one request in flight at a time; the output register lets the next request in while a result waits
// the ring is a single ram, written at most once per cycle; the fill register sets the length of a resync fill
// synchronous active-high reset clears control state and registers; ring contents stay undefined
// depends on jcsr_pkg and jcsr_ram
module jitter_checked_sample_ring
   import jcsr_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEF,
   parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // timestamp_us[31:0], adc_sample[43:32], zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // operation[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // sample_value[11:0], sync_state[13:12],
                                             // gap_us[45:14], zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser,  // sample_valid[0], snapshot_taken[1], gap_valid[2]
   output logic                  rsp_tlast,  // last_of_frame
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int FRM_W = $clog2(FRAME_LENGTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
   localparam logic [FRM_W:0]   FRM_END  = (FRM_W + 1)'(FRAME_LENGTH);

   // registers
   state_type           state_ff, state_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic [FILL_W-1:0]   fill_cfg_ff, fill_cfg_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic [TIME_W-1:0]   good_time_ff, good_time_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                armed_ff, armed_in;
   logic [FRM_W-1:0]    frame_ff, frame_in;
   logic [FILL_W-1:0]   fill_left_ff, fill_left_in;
   logic [TIME_W-1:0]   ts_ff, ts_in;
   logic [SAMPLE_W-1:0] adc_ff, adc_in;
   logic [TIME_W-1:0]   dev_ff, dev_in;
   rsp_type             res_ff, res_in;
   rsp_type             out_ff, out_in;
   logic                out_vld_ff, out_vld_in;

   // ring ram
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic                ram_rd_en;
   logic [SAMPLE_W-1:0] ram_rd_data;

   logic                req_fire;
   logic                csr_write;
   logic [OP_W-1:0]     req_op;
   logic                bad;
   logic [TIME_W:0]     neg_sum;
   logic [FRM_W:0]      frame_inc;
   logic [IDX_W-1:0]    wr_idx_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = req_tuser;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_ff.gap_us, out_ff.sync_state, out_ff.sample_value};
   assign rsp_tuser  = {out_ff.gap_valid, out_ff.snapshot_taken, out_ff.sample_valid};
   assign rsp_tlast  = out_ff.last_of_frame;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_PERIOD:    csr_prdata = {16'd0, period_ff};
         REG_TOLERANCE: csr_prdata = {16'd0, tol_ff};
         REG_FILL:      csr_prdata = {29'd0, fill_cfg_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // a negative deviation is bad when adding the tolerance gives no carry out
   assign neg_sum = {1'b0, dev_ff} + {17'd0, tol_ff};
   assign bad = dev_ff[TIME_W-1] ? !neg_sum[TIME_W] : (dev_ff > {16'd0, tol_ff});

   assign frame_inc   = {1'b0, frame_ff} + 1'b1;
   assign wr_idx_step = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      tol_in       = tol_ff;
      fill_cfg_in  = fill_cfg_ff;
      mode_in      = mode_ff;
      prev_time_in = prev_time_ff;
      good_time_in = good_time_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      armed_in     = armed_ff;
      frame_in     = frame_ff;
      fill_left_in = fill_left_ff;
      ts_in        = ts_ff;
      adc_in       = adc_ff;
      dev_in       = dev_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff;
      ram_rd_en    = 1'b0;

      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_PERIOD:    period_in   = csr_pwdata[PERIOD_W-1:0];
            REG_TOLERANCE: tol_in      = csr_pwdata[TOL_W-1:0];
            REG_FILL:      fill_cfg_in = csr_pwdata[FILL_W-1:0];
            default:       ;
         endcase
      end

      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ts_in             = req_tdata[TIME_W-1:0];
               adc_in            = req_tdata[TIME_W +: SAMPLE_W];
               res_in            = '0;
               res_in.sync_state = mode_ff;
               case (req_op)
                  OP_SAMPLE: state_in = ST_CALC;
                  OP_ARM: begin
                     armed_in = 1'b1;
                     state_in = ST_DONE;
                  end
                  OP_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_RDATA;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CALC: begin
            dev_in   = ts_ff - prev_time_ff - {16'd0, period_ff};
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            prev_time_in = ts_ff;
            state_in     = ST_SNAP;
            case (mode_ff)
               MODE_IN_SYNC: begin
                  if (bad) begin
                     mode_in = MODE_WAIT;
                  end else begin
                     ram_wr_en    = 1'b1;
                     wr_idx_in    = wr_idx_step;
                     good_time_in = ts_ff;
                  end
               end
               MODE_WAIT: mode_in = MODE_RESYNC;
               MODE_RESYNC: begin
                  if (bad) begin
                     mode_in = MODE_WAIT;
                  end else begin
                     res_in.gap_us    = ts_ff - good_time_ff;
                     res_in.gap_valid = 1'b1;
                     good_time_in     = ts_ff;
                     mode_in          = MODE_IN_SYNC;
                     fill_left_in     = fill_cfg_ff;
                     if (fill_cfg_ff != '0) begin
                        state_in = ST_FILL;
                     end
                  end
               end
               default: mode_in = MODE_IN_SYNC;
            endcase
         end
         ST_FILL: begin
            // one copy per cycle through the single write port
            ram_wr_en    = 1'b1;
            wr_idx_in    = wr_idx_step;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == FILL_W'(1)) begin
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            res_in.sync_state = mode_ff;
            if (armed_ff && (mode_ff == MODE_IN_SYNC)) begin
               rd_idx_in             = (wr_idx_ff == '0) ? IDX_LAST : wr_idx_ff - 1'b1;
               armed_in              = 1'b0;
               frame_in              = '0;
               res_in.snapshot_taken = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_RDATA: begin
            res_in.sample_value = ram_rd_data;
            res_in.sample_valid = 1'b1;
            rd_idx_in = (rd_idx_ff == '0) ? IDX_LAST : rd_idx_ff - 1'b1;
            if (frame_inc == FRM_END) begin
               res_in.last_of_frame = 1'b1;
               frame_in             = '0;
            end else begin
               frame_in = frame_inc[FRM_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RST;
         tol_ff       <= TOL_RST;
         fill_cfg_ff  <= FILL_RST;
         mode_ff      <= MODE_IN_SYNC;
         prev_time_ff <= '0;
         good_time_ff <= '0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         armed_ff     <= 1'b0;
         frame_ff     <= '0;
         fill_left_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         tol_ff       <= tol_in;
         fill_cfg_ff  <= fill_cfg_in;
         mode_ff      <= mode_in;
         prev_time_ff <= prev_time_in;
         good_time_ff <= good_time_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         armed_ff     <= armed_in;
         frame_ff     <= frame_in;
         fill_left_ff <= fill_left_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff  <= ts_in;
      adc_ff <= adc_in;
      dev_ff <= dev_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   // one request at a time, so a ring read never meets a write to the same entry
   jcsr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (adc_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

endmodule

### rtl/core/jcsr_ram.sv
// jcsr_ram: generic single write port, single read port ram with registered read
// no dependencies
module jcsr_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/jcsr_checker.sv
// jcsr_checker: port-level assertions on the result stream of the sample ring
// depends on jcsr_pkg; bound to jitter_checked_sample_ring below
module jcsr_checker
   import jcsr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // a read result never carries a gap report
   a_read_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[2]))
      else $error("read result also reports a gap");

   // end of frame only on a read result
   a_last_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("last_of_frame without a read");

   // snapshot and gap reports leave the machine in sync
   a_in_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2])) |-> (rsp_tdata[13:12] == MODE_IN_SYNC))
      else $error("snapshot or gap reported outside sync");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind jitter_checked_sample_ring jcsr_checker u_jcsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
